[design/slcd_fmt_pkg.sv]
// ----------------------------------------------------------------------------
// slcd_fmt_pkg
// Types, glyph table and helpers for the segment LCD frame formatter.
// ----------------------------------------------------------------------------
package slcd_fmt_pkg;

	localparam logic [7:0] GLYPH_HI_H = 8'h6E;
	localparam logic [7:0] GLYPH_HI_I = 8'h20;
	localparam logic [7:0] GLYPH_LO_L = 8'h70;
	localparam logic [7:0] GLYPH_LO_O = 8'h36;

	localparam logic signed [15:0] BIG_LIMIT        = 16'sd1999;
	localparam logic signed [15:0] POINT_LIMIT_HIGH = 16'sd1995;
	localparam logic signed [15:0] POINT_LIMIT_LOW  = -16'sd95;
	localparam logic signed [15:0] SMALL_LIMIT_HIGH = 16'sd99;
	localparam logic signed [15:0] SMALL_LIMIT_LOW  = -16'sd9;

	localparam logic DISPLAY_ENABLE_RESET = 1'b1;

	typedef struct packed {
		logic signed [15:0] big_value;
		logic signed [15:0] small_value;
		logic               percent_sign;
		logic               battery_low;
		logic [2:0]         smiley_code;
		logic [2:0]         unit_code;
		logic               link_connected;
	} req_t;

	typedef struct packed {
		logic [7:0] seg_byte0;
		logic [7:0] seg_byte1;
		logic [7:0] seg_byte2;
		logic [7:0] seg_byte3;
		logic [7:0] seg_byte4;
		logic [7:0] seg_byte5;
		logic       send_frame;
	} frm_t;

	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0:    g = 8'hFA;
			4'd1:    g = 8'h0A;
			4'd2:    g = 8'hBC;
			4'd3:    g = 8'h9E;
			4'd4:    g = 8'h4E;
			4'd5:    g = 8'hD6;
			4'd6:    g = 8'hF6;
			4'd7:    g = 8'h8A;
			4'd8:    g = 8'hFE;
			4'd9:    g = 8'hDE;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// reciprocal multiply, exact for inputs below 2560
	function automatic logic [7:0] div10(input logic [11:0] x);
		logic [23:0] p;
		p = {12'd0, x} * 24'd3277;
		return p[22:15];
	endfunction

	// reciprocal multiply, exact for inputs below 3200
	function automatic logic [4:0] div100(input logic [11:0] x);
		logic [23:0] p;
		p = {12'd0, x} * 24'd1311;
		return p[21:17];
	endfunction

endpackage

[design/segment_lcd_frame_formatter_top.sv]
// ----------------------------------------------------------------------------
// segment_lcd_frame_formatter_top
// Builds a six-byte segment LCD frame per request and flags changed frames.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one display request a beat.
//   frm channel (frm_valid / frm_stall / frm) returns one frame per request,
//   with send_frame set when the frame differs from the last one flagged
//   and the display is enabled.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes display_enable;
//   cfg_ready is always high. Write it only while no request is in flight.
// Path: a request is taken into the input register, and its frame is then
//   registered into the result register and presented on frm.
// Throughput: one request per cycle while frm_stall is low; the rounding
//   divide of the big value feeding the digit split (parallel divides by ten
//   and a hundred) is the longest path between registers.
// Reset: clears both pipeline valids and the stored last frame, and sets
//   display_enable to 1.
// Stall: when frm_stall holds a frame, the input register still takes one
//   more request; after that req_stall rises until the frame is taken.
// ----------------------------------------------------------------------------
module segment_lcd_frame_formatter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  slcd_fmt_pkg::req_t   req,
	output logic                 frm_valid,
	input  logic                 frm_stall,
	output slcd_fmt_pkg::frm_t   frm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);
	import slcd_fmt_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        frm_valid_q;
	frm_t        frm_q;
	logic        display_enable_q;
	logic [47:0] last_frame_q;

	logic        out_adv;
	logic        s1_adv;
	logic        s1_move;

	logic               big_hi;
	logic               big_lo;
	logic               big_point;
	logic               big_neg;
	logic [15:0]        big_abs;
	logic [11:0]        big_round;
	logic [11:0]        big_m;
	logic [7:0]         q1;
	logic [4:0]         q2;
	logic               q3;
	logic [3:0]         d0;
	logic [3:0]         d1;
	logic [3:0]         d2;

	logic               sm_hi;
	logic               sm_lo;
	logic               sm_neg;
	logic [15:0]        sm_abs;
	logic [7:0]         sm_q;
	logic [3:0]         sm_d;
	logic               sm_has_tens;
	logic [7:0]         sm_tens;
	logic [7:0]         sm_ones;

	logic [7:0]         f0, f1, f2, f3, f4, f5;
	logic [47:0]        frame;
	logic               send;

	assign out_adv   = !frm_valid_q || !frm_stall;
	assign s1_adv    = !valid_s1 || out_adv;
	assign s1_move   = valid_s1 && out_adv;
	assign req_stall = !s1_adv;
	assign cfg_ready = 1'b1;
	assign frm_valid = frm_valid_q;
	assign frm       = frm_q;

	// big field
	always_comb begin
		big_hi    = req_s1.big_value > BIG_LIMIT;
		big_lo    = req_s1.big_value < -BIG_LIMIT;
		big_point = !(req_s1.big_value > POINT_LIMIT_HIGH ||
			req_s1.big_value < POINT_LIMIT_LOW);
		big_neg   = req_s1.big_value < 16'sd0;
		big_abs   = big_neg ? 16'(-req_s1.big_value) : 16'(req_s1.big_value);
		big_round = 12'(div10(big_abs[11:0] + 12'd5));
		big_m     = big_point ? big_abs[11:0] : big_round;
		q1 = div10(big_m);
		q2 = div100(big_m);
		q3 = big_m > 12'd999;
		d0 = 4'(big_m - 12'(q1) * 12'd10);
		d1 = 4'(q1 - 8'(q2) * 8'd10);
		d2 = 4'(q2 - (q3 ? 5'd10 : 5'd0));
	end

	// small field
	always_comb begin
		sm_hi       = req_s1.small_value > SMALL_LIMIT_HIGH;
		sm_lo       = req_s1.small_value < SMALL_LIMIT_LOW;
		sm_neg      = req_s1.small_value < 16'sd0;
		sm_abs      = sm_neg ? 16'(-req_s1.small_value) : 16'(req_s1.small_value);
		sm_q        = div10({5'd0, sm_abs[6:0]});
		sm_d        = 4'(sm_abs[7:0] - 8'(sm_q * 8'd10));
		sm_has_tens = 1'b1;
		sm_tens     = 8'h00;
		sm_ones     = 8'h00;
		if (sm_hi) begin
			sm_tens = GLYPH_HI_H;
			sm_ones = GLYPH_HI_I;
		end else if (sm_lo) begin
			sm_tens = GLYPH_LO_L;
			sm_ones = GLYPH_LO_O;
		end else begin
			sm_has_tens = sm_abs[6:0] > 7'd9;
			sm_tens     = sm_has_tens ? digit_glyph(sm_q[3:0]) : 8'h00;
			sm_ones     = digit_glyph(sm_d);
		end
	end

	// frame assembly
	always_comb begin
		f0 = 8'h00;
		f1 = 8'h00;
		f2 = 8'h00;
		f3 = 8'h00;
		if (big_hi) begin
			f0 = GLYPH_HI_H;
			f1 = GLYPH_HI_I;
		end else if (big_lo) begin
			f0 = GLYPH_LO_L;
			f1 = GLYPH_LO_O;
		end else begin
			f3[0] = big_neg;
			f0[0] = big_m > 12'd999;
			if (big_m > 12'd99) begin
				f0 = f0 | digit_glyph(d2);
			end
			if (big_m > 12'd9 || big_point) begin
				f1 = digit_glyph(d1);
			end
			f1[0] = big_point;
			f2 = digit_glyph(d0);
		end
		f3[6] = req_s1.battery_low;
		f3[3] = req_s1.smiley_code[0];
		f3[2] = req_s1.smiley_code[1];
		f3[7] = req_s1.smiley_code[2];
		f3[5] = req_s1.unit_code[0];
		f3[4] = req_s1.unit_code[2];
		f2[0] = f2[0] | req_s1.unit_code[1];

		f4 = {7'd0, req_s1.percent_sign};
		f5 = {5'd0, !sm_hi && !sm_lo && sm_neg, 1'b0, req_s1.link_connected};
		if (sm_has_tens) begin
			f5 = f5 | (sm_tens & 8'h0E);
			f4 = f4 | (sm_tens & 8'hF0);
		end
		f4 = f4 | (sm_ones & 8'h0E);
		f5 = f5 | (sm_ones & 8'hF0);

		frame = {f0, f1, f2, f3, f4, f5};
		send  = display_enable_q && (frame != last_frame_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			frm_valid_q      <= 1'b0;
			display_enable_q <= DISPLAY_ENABLE_RESET;
			last_frame_q     <= '0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= req_valid;
			end
			if (out_adv) begin
				frm_valid_q <= valid_s1;
			end
			if (cfg_valid && cfg_ready) begin
				display_enable_q <= cfg_data;
			end
			if (s1_move && send) begin
				last_frame_q <= frame;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && req_valid) begin
			req_s1 <= req;
		end
		if (s1_move) begin
			frm_q <= {frame, send};
		end
	end

endmodule

[design/slcd_fmt_checker.sv]
// ----------------------------------------------------------------------------
// slcd_fmt_checker
// Port-level checks for the segment LCD frame formatter.
// ----------------------------------------------------------------------------
module slcd_fmt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_stall,
	input  logic               frm_valid,
	input  logic               frm_stall,
	input  slcd_fmt_pkg::frm_t frm
);
	import slcd_fmt_pkg::*;

	logic frm_beat;
	assign frm_beat = frm_valid && !frm_stall;

	// a held frame stays put
	a_frm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_stall |=> frm_valid && $stable(frm))
		else $error("frame changed while stalled");

	// input side only backs up when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> frm_valid && frm_stall)
		else $error("request stalled without a stalled frame");

	// a repeat of the frame delivered just before is never flagged
	a_no_resend: assert property (@(posedge clk) disable iff (!arst_n)
		frm_beat ##1 (frm_beat &&
			frm.seg_byte0 == $past(frm.seg_byte0) &&
			frm.seg_byte1 == $past(frm.seg_byte1) &&
			frm.seg_byte2 == $past(frm.seg_byte2) &&
			frm.seg_byte3 == $past(frm.seg_byte3) &&
			frm.seg_byte4 == $past(frm.seg_byte4) &&
			frm.seg_byte5 == $past(frm.seg_byte5)) |-> !frm.send_frame)
		else $error("unchanged frame flagged for send");

endmodule

bind segment_lcd_frame_formatter_top slcd_fmt_checker u_slcd_fmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.frm_valid (frm_valid),
	.frm_stall (frm_stall),
	.frm       (frm)
);
